/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL files; only the allocator includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge while reset is released.
`define BPFA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// An implication: when the cause holds, the effect holds in the same cycle.
`define BPFA_ASSERT_IMPL(label, clk, rstn, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cause) |-> (effect)) \
        else $error(msg);

`endif

/* rtl/core/bpfa_pkg.sv */
package bpfa_pkg;

    localparam int MAX_FRAMES = 32768;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;
    localparam int GROUPS     = MAP_WORDS / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int GRP_W      = $clog2(GROUPS);
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int CNT_W      = 16;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 27;

    typedef logic [WORD_BITS-1:0] word_t;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    // Configuration register indexes.
    localparam logic [0:0] REG_MAX_BLOCKS      = 1'd0;
    localparam logic [0:0] REG_RESERVED_FRAMES = 1'd1;

    // Access request from the controller to the map store. The summary write,
    // the summary read and the top-level set and clear all use sum_addr.
    typedef struct packed {
        logic               word_rd;
        logic               word_wr;
        logic [WADDR_W-1:0] word_addr;
        word_t              word_wdata;
        logic               sum_rd;
        logic               sum_wr;
        logic [GRP_W-1:0]   sum_addr;
        word_t              sum_wdata;
        logic               top_load;
        word_t              top_wdata;
        logic               top_set;
        logic               top_clr;
    } map_cmd_t;

    // Index of the lowest clear bit; zero when the word is full.
    function automatic logic [BIT_W-1:0] lowest_zero(input word_t w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic word_t bit_mask(input logic [BIT_W-1:0] n);
        return word_t'(1) << n;
    endfunction

    function automatic word_t low_mask(input logic [BIT_W-1:0] n);
        return (word_t'(1) << n) - word_t'(1);
    endfunction

    // Word idx of a map whose first (whole * WORD_BITS + part) bits are set.
    function automatic word_t fill_word(input logic [WADDR_W:0] whole,
                                        input logic [BIT_W-1:0] part,
                                        input logic [WADDR_W-1:0] idx);
        word_t w;
        if (whole > {1'b0, idx}) begin
            w = '1;
        end else if (whole == {1'b0, idx}) begin
            w = low_mask(part);
        end else begin
            w = '0;
        end
        return w;
    endfunction

endpackage

/* rtl/core/bpfa_map.sv */
module bpfa_map (
    input  logic               aclk,
    input  logic               aresetn,
    input  bpfa_pkg::map_cmd_t cmd,
    output bpfa_pkg::word_t    word_rdata,
    output bpfa_pkg::word_t    sum_rdata,
    output bpfa_pkg::word_t    top_bits
);
    import bpfa_pkg::*;

    // One bit per frame, and one bit per map word that is set when the word is full.
    word_t bitmap_mem  [MAP_WORDS];
    word_t summary_mem [GROUPS];

    word_t word_rdata_reg;
    word_t sum_rdata_reg;
    word_t top_reg;
    word_t top_next;

    always_ff @(posedge aclk) begin
        if (cmd.word_wr) begin
            bitmap_mem[cmd.word_addr] <= cmd.word_wdata;
        end
        if (cmd.word_rd) begin
            word_rdata_reg <= bitmap_mem[cmd.word_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum_wr) begin
            summary_mem[cmd.sum_addr] <= cmd.sum_wdata;
        end
        if (cmd.sum_rd) begin
            sum_rdata_reg <= summary_mem[cmd.sum_addr];
        end
    end

    // Top level of the tree: a bit per summary word that is all ones.
    always_comb begin
        top_next = top_reg;
        if (cmd.top_load) begin
            top_next = cmd.top_wdata;
        end else if (cmd.top_set) begin
            top_next = top_reg | bit_mask(cmd.sum_addr);
        end else if (cmd.top_clr) begin
            top_next = top_reg & ~bit_mask(cmd.sum_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg <= '0;
        end else begin
            top_reg <= top_next;
        end
    end

    assign word_rdata = word_rdata_reg;
    assign sum_rdata  = sum_rdata_reg;
    assign top_bits   = top_reg;

endmodule

/* rtl/core/bitmap_page_frame_allocator.sv */
// Allocate passes through S_A_SUM, S_A_WORD and S_RESP before its result is registered, free through
// S_F_WORD and S_RESP, and an unknown opcode, a full map or an out-of-range free go straight to S_RESP.
// Init rewrites all 1024 map words, one per cycle, then passes through S_RESP to raise its result.
// One item is worked on at a time; a new item is taken once the last result is registered.
// Reset (aresetn low, synchronous) starts a clearing pass over the map; no item is accepted meanwhile.
module bitmap_page_frame_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] free_address
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [26:0] address, [42:27] used_count,
                                        // [58:43] free_count, [63:59] zero
    output logic [0:0]  m_axis_tuser,   // [0] ok
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bpfa_pkg::*;

    `include "assert_macros.svh"

    // Controller states. The sweep state serves both the init operation and the
    // clearing pass after reset; only the former produces a result.
    localparam logic [2:0] S_SWEEP  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_A_SUM  = 3'd2;
    localparam logic [2:0] S_A_WORD = 3'd3;
    localparam logic [2:0] S_F_WORD = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    localparam logic [CNT_W-1:0] FRAMES_CAP = CNT_W'(MAX_FRAMES);

    logic [2:0]         state_reg, state_next;
    logic [WADDR_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic               sweep_resp_reg, sweep_resp_next;
    logic [CNT_W-1:0]   resv_reg, resv_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   max_blocks_reg;
    logic [CNT_W-1:0]   reserved_frames_reg;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    word_t              sum_q_reg, sum_q_next;
    logic               ok_reg, ok_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               m_valid_reg, m_valid_next;
    logic [63:0]        m_data_reg, m_data_next;
    logic               m_ok_reg, m_ok_next;

    map_cmd_t cmd;
    word_t    word_rdata;
    word_t    sum_rdata;
    word_t    top_bits;

    bpfa_map u_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .word_rdata (word_rdata),
        .sum_rdata  (sum_rdata),
        .top_bits   (top_bits)
    );

    logic [CNT_W-1:0]   limit;
    logic [CNT_W-1:0]   resv_capped;
    logic [CNT_W-1:0]   free_cnt;
    logic               accept;
    logic [19:0]        free_frame;
    logic               free_in_range;
    logic [GRP_W-1:0]   alloc_grp;
    logic [BIT_W-1:0]   sum_pick;
    logic [BIT_W-1:0]   bit_pick;
    logic [FRAME_W-1:0] pick_frame;
    logic               pick_ok;
    word_t              word_set;
    word_t              sum_set;
    logic [WADDR_W:0]   full_words;
    word_t              top_fill;
    logic               load_out;

    // The managed limit saturates at the map size, as does the init reserve.
    assign limit       = (max_blocks_reg > FRAMES_CAP) ? FRAMES_CAP : max_blocks_reg;
    assign resv_capped = (reserved_frames_reg > FRAMES_CAP) ? FRAMES_CAP : reserved_frames_reg;
    assign free_cnt    = (used_reg >= limit) ? '0 : limit - used_reg;

    assign accept        = s_axis_tvalid && (state_reg == S_IDLE);
    assign s_axis_tready = (state_reg == S_IDLE);

    // A free address names frame address / page size; anything at or above the
    // limit, including addresses past the map, is refused.
    assign free_frame    = s_axis_tdata[31:PAGE_SHIFT];
    assign free_in_range = free_frame < {4'b0, limit};

    // Allocation walks the three-level tree: the top register picks the lowest
    // group with a non-full word, the summary word picks that word, and the map
    // word picks the bit. The global lowest free frame is found; if it lies at or
    // above the limit then no frame below the limit is free.
    assign alloc_grp  = lowest_zero(top_bits);
    assign sum_pick   = lowest_zero(sum_rdata);
    assign bit_pick   = lowest_zero(word_rdata);
    assign pick_frame = {frame_reg[FRAME_W-1:BIT_W], bit_pick};
    assign pick_ok    = {1'b0, pick_frame} < limit;
    assign word_set   = word_rdata | bit_mask(bit_pick);
    assign sum_set    = sum_q_reg | bit_mask(frame_reg[2*BIT_W-1:BIT_W]);

    // During a sweep, the number of map words that are wholly reserved.
    assign full_words = resv_reg[CNT_W-1:BIT_W];

    always_comb begin
        top_fill = '0;
        for (int g = 0; g < WORD_BITS; g++) begin
            top_fill[g] = full_words[WADDR_W:BIT_W] > 6'(g);
        end
    end

    assign load_out = (state_reg == S_RESP) && (!m_valid_reg || m_axis_tready);

    always_comb begin
        state_next      = state_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        sweep_resp_next = sweep_resp_reg;
        resv_next       = resv_reg;
        used_next       = used_reg;
        frame_next      = frame_reg;
        sum_q_next      = sum_q_reg;
        ok_next         = ok_reg;
        addr_next       = addr_reg;
        cmd             = '0;

        unique case (state_reg)
            S_SWEEP: begin
                // Rewrite one map word a cycle; while the count is below 32 the summary
                // words are also rewritten, and at count zero the top register is loaded.
                cmd.word_wr    = 1'b1;
                cmd.word_addr  = sweep_cnt_reg;
                cmd.word_wdata = fill_word(full_words, resv_reg[BIT_W-1:0], sweep_cnt_reg);
                cmd.sum_wr     = (sweep_cnt_reg[WADDR_W-1:GRP_W] == '0);
                cmd.sum_addr   = sweep_cnt_reg[GRP_W-1:0];
                cmd.sum_wdata  = fill_word({5'b0, full_words[WADDR_W:BIT_W]},
                                           full_words[BIT_W-1:0],
                                           {5'b0, sweep_cnt_reg[GRP_W-1:0]});
                cmd.top_load   = (sweep_cnt_reg == '0);
                cmd.top_wdata  = top_fill;
                sweep_cnt_next = sweep_cnt_reg + WADDR_W'(1);
                if (&sweep_cnt_reg) begin
                    state_next = sweep_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    ok_next   = 1'b0;
                    addr_next = '0;
                    unique case (s_axis_tuser)
                        OP_INIT: begin
                            resv_next       = resv_capped;
                            used_next       = resv_capped;
                            sweep_cnt_next  = '0;
                            sweep_resp_next = 1'b1;
                            ok_next         = 1'b1;
                            state_next      = S_SWEEP;
                        end
                        OP_ALLOC: begin
                            if (&top_bits) begin
                                state_next = S_RESP;
                            end else begin
                                cmd.sum_rd   = 1'b1;
                                cmd.sum_addr = alloc_grp;
                                frame_next   = {alloc_grp, 10'b0};
                                state_next   = S_A_SUM;
                            end
                        end
                        OP_FREE: begin
                            if (free_in_range) begin
                                cmd.word_rd   = 1'b1;
                                cmd.word_addr = free_frame[FRAME_W-1:BIT_W];
                                cmd.sum_rd    = 1'b1;
                                cmd.sum_addr  = free_frame[FRAME_W-1:FRAME_W-GRP_W];
                                frame_next    = free_frame[FRAME_W-1:0];
                                state_next    = S_F_WORD;
                            end else begin
                                state_next = S_RESP;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_A_SUM: begin
                cmd.word_rd   = 1'b1;
                cmd.word_addr = {frame_reg[FRAME_W-1:FRAME_W-GRP_W], sum_pick};
                frame_next    = {frame_reg[FRAME_W-1:FRAME_W-GRP_W], sum_pick, 5'b0};
                sum_q_next    = sum_rdata;
                state_next    = S_A_WORD;
            end
            S_A_WORD: begin
                if (pick_ok) begin
                    cmd.word_wr    = 1'b1;
                    cmd.word_addr  = frame_reg[FRAME_W-1:BIT_W];
                    cmd.word_wdata = word_set;
                    cmd.sum_addr   = frame_reg[FRAME_W-1:FRAME_W-GRP_W];
                    if (&word_set) begin
                        cmd.sum_wr    = 1'b1;
                        cmd.sum_wdata = sum_set;
                        cmd.top_set   = &sum_set;
                    end
                    used_next = used_reg + CNT_W'(1);
                    ok_next   = 1'b1;
                    addr_next = {pick_frame, 12'b0};
                end
                state_next = S_RESP;
            end
            S_F_WORD: begin
                if (word_rdata[frame_reg[BIT_W-1:0]]) begin
                    // The word can no longer be full, so its summary bit and
                    // its group's top bit both clear.
                    cmd.word_wr    = 1'b1;
                    cmd.word_addr  = frame_reg[FRAME_W-1:BIT_W];
                    cmd.word_wdata = word_rdata & ~bit_mask(frame_reg[BIT_W-1:0]);
                    cmd.sum_wr     = 1'b1;
                    cmd.sum_addr   = frame_reg[FRAME_W-1:FRAME_W-GRP_W];
                    cmd.sum_wdata  = sum_rdata & ~bit_mask(frame_reg[2*BIT_W-1:BIT_W]);
                    cmd.top_clr    = 1'b1;
                    used_next      = (used_reg == '0) ? '0 : used_reg - CNT_W'(1);
                    ok_next        = 1'b1;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: holds a result until it is taken, so the controller can
    // start the next item meanwhile.
    always_comb begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_ok_next    = m_ok_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = {5'b0, free_cnt, used_reg, addr_reg};
            m_ok_next    = ok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= S_SWEEP;
            sweep_cnt_reg       <= '0;
            sweep_resp_reg      <= 1'b0;
            resv_reg            <= '0;
            used_reg            <= '0;
            max_blocks_reg      <= FRAMES_CAP;
            reserved_frames_reg <= CNT_W'(256);
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            sweep_resp_reg <= sweep_resp_next;
            resv_reg       <= resv_next;
            used_reg       <= used_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_MAX_BLOCKS:      max_blocks_reg      <= cfg_data;
                    REG_RESERVED_FRAMES: reserved_frames_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg  <= frame_next;
        sum_q_reg  <= sum_q_next;
        ok_reg     <= ok_next;
        addr_reg   <= addr_next;
        m_data_reg <= m_data_next;
        m_ok_reg   <= m_ok_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_ok_reg;

    // The tree must stay consistent: a group chosen through a clear top bit has a
    // non-full summary word, and a word chosen through it has a clear bit.
    `BPFA_ASSERT_IMPL(a_sum_not_full, aclk, aresetn, state_reg == S_A_SUM, !(&sum_rdata),
        "summary word picked for allocation is full")
    `BPFA_ASSERT_IMPL(a_word_not_full, aclk, aresetn, state_reg == S_A_WORD, !(&word_rdata),
        "map word picked for allocation is full")
    `BPFA_ASSERT(a_used_bound, aclk, aresetn, used_reg <= FRAMES_CAP,
        "used frame count exceeds the map size")
    `BPFA_ASSERT_IMPL(a_result_source, aclk, aresetn, $rose(m_valid_reg),
        $past(state_reg) == S_RESP, "result raised outside the response state")

endmodule
